// ===== design/cursor_line_editor_list_core_assert.svh =====
// assertion macros for the cursor line editor core
// no dependencies; included by the top level
`ifndef CURSOR_LINE_EDITOR_LIST_CORE_ASSERT_SVH
`define CURSOR_LINE_EDITOR_LIST_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CLE_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("cle check failed");

// next-cycle implication, disabled in reset
`define CLE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("cle check failed");

`endif

// ===== design/cle_pkg.sv =====
// shared codes, widths and controller/datapath interface structs
// no dependencies
`default_nettype none

package cle_pkg;

  localparam int NODES_DEF = 1024;
  localparam int OP_W      = 3;
  localparam int CHAR_W    = 8;
  localparam int STAT_W    = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_LEFT   = 3'd1;
  localparam logic [OP_W-1:0] OP_RIGHT  = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_REWIND = 3'd4;
  localparam logic [OP_W-1:0] OP_READ   = 3'd5;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic              rd_prev;      // read prev link at cursor
    logic              rd_next;      // read next link
    logic              rd_from_read; // next link read at read pointer, not cursor
    logic              wr_new;       // fill new node: char, prev = cursor
    logic              wr_fwd;       // new node next = after, after prev = new node
    logic              wr_head;      // cursor next = new node, cursor moves, pool advances
    logic              cur_to_prev;
    logic              cur_to_next;
    logic              unlink;       // drop node left of cursor
    logic              read_clr;
    logic              read_adv;     // read pointer steps, fetch its char
    logic              emit;
    logic [STAT_W-1:0] status;
    logic              at_end;
    logic              take_char;
  } cle_cmd_t;

  // flags from the datapath to the controller
  typedef struct packed {
    logic cur_zero;
    logic pool_full;
    logic after_zero;
  } cle_stat_t;

endpackage

`default_nettype wire

// ===== design/cle_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/cle_ctrl.sv =====
// command sequencer for the line editor
// depends on cle_pkg
`default_nettype none

module cle_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [cle_pkg::OP_W-1:0]   op,
  input  wire cle_pkg::cle_stat_t         stat,
  output cle_pkg::cle_cmd_t               cmd,
  output logic                            busy
);
  import cle_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_LINK = 3'd1;
  localparam logic [2:0] S_INS_HEAD = 3'd2;
  localparam logic [2:0] S_MOVE_L   = 3'd3;
  localparam logic [2:0] S_MOVE_R   = 3'd4;
  localparam logic [2:0] S_DEL      = 3'd5;
  localparam logic [2:0] S_RD_LINK  = 3'd6;
  localparam logic [2:0] S_RD_CHAR  = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (op)
            OP_INSERT: begin
              if (stat.pool_full) begin
                cmd.emit   = 1'b1;
                cmd.status = ST_FULL;
              end else begin
                cmd.wr_new  = 1'b1;
                cmd.rd_next = 1'b1;
                state_nxt   = S_INS_LINK;
              end
            end
            OP_LEFT: begin
              if (stat.cur_zero) begin
                cmd.emit   = 1'b1;
                cmd.status = ST_IGNORED;
              end else begin
                cmd.rd_prev = 1'b1;
                state_nxt   = S_MOVE_L;
              end
            end
            OP_RIGHT: begin
              cmd.rd_next = 1'b1;
              state_nxt   = S_MOVE_R;
            end
            OP_DELETE: begin
              if (stat.cur_zero) begin
                cmd.emit   = 1'b1;
                cmd.status = ST_IGNORED;
              end else begin
                cmd.rd_prev = 1'b1;
                cmd.rd_next = 1'b1;
                state_nxt   = S_DEL;
              end
            end
            OP_REWIND: begin
              cmd.read_clr = 1'b1;
              cmd.emit     = 1'b1;
              cmd.status   = ST_DONE;
            end
            OP_READ: begin
              cmd.rd_next      = 1'b1;
              cmd.rd_from_read = 1'b1;
              state_nxt        = S_RD_LINK;
            end
            default: begin
              cmd.emit   = 1'b1;
              cmd.status = ST_IGNORED;
            end
          endcase
        end
      end
      S_INS_LINK: begin
        cmd.wr_fwd = 1'b1;
        state_nxt  = S_INS_HEAD;
      end
      S_INS_HEAD: begin
        cmd.wr_head = 1'b1;
        cmd.emit    = 1'b1;
        cmd.status  = ST_DONE;
        state_nxt   = S_IDLE;
      end
      S_MOVE_L: begin
        cmd.cur_to_prev = 1'b1;
        cmd.emit        = 1'b1;
        cmd.status      = ST_DONE;
        state_nxt       = S_IDLE;
      end
      S_MOVE_R: begin
        cmd.emit = 1'b1;
        if (stat.after_zero) begin
          cmd.status = ST_IGNORED;
        end else begin
          cmd.cur_to_next = 1'b1;
          cmd.status      = ST_DONE;
        end
        state_nxt = S_IDLE;
      end
      S_DEL: begin
        cmd.unlink = 1'b1;
        cmd.emit   = 1'b1;
        cmd.status = ST_DONE;
        state_nxt  = S_IDLE;
      end
      S_RD_LINK: begin
        if (stat.after_zero) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_IGNORED;
          cmd.at_end = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.read_adv = 1'b1;
          state_nxt    = S_RD_CHAR;
        end
      end
      S_RD_CHAR: begin
        cmd.emit      = 1'b1;
        cmd.status    = ST_DONE;
        cmd.take_char = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/cle_dpath.sv =====
// node pool memories, cursor/read pointers, pool counter and result register
// depends on cle_pkg and cle_ram
`default_nettype none

module cle_dpath #(
  parameter int NODES = cle_pkg::NODES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cle_pkg::cle_cmd_t             cmd,
  input  wire logic [cle_pkg::CHAR_W-1:0]    char_in,
  output cle_pkg::cle_stat_t                 stat,
  output logic                               out_valid,
  output logic      [cle_pkg::STAT_W-1:0]    out_status,
  output logic      [cle_pkg::CHAR_W-1:0]    out_char_out,
  output logic                               out_at_end
);
  import cle_pkg::*;

  localparam int          AW       = $clog2(NODES);
  localparam logic [AW:0] FULL_CNT = (AW+1)'(NODES);

  logic [AW-1:0]     cursor_r, cursor_nxt;
  logic [AW-1:0]     read_r, read_nxt;
  logic [AW:0]       free_r, free_nxt;
  logic              head_ok_r, head_ok_nxt;
  logic              nzero_r, nzero_nxt;
  logic              valid_r;
  logic [STAT_W-1:0] status_r;
  logic [CHAR_W-1:0] char_r;
  logic              end_r;

  logic [AW-1:0]     new_node;
  logic [AW-1:0]     link_next, link_prev;
  logic [AW-1:0]     next_rdata, prev_rdata;
  logic [CHAR_W-1:0] char_rdata;

  logic              next_we, prev_we;
  logic [AW-1:0]     next_waddr, next_wdata, next_raddr;
  logic [AW-1:0]     prev_waddr, prev_wdata;

  assign new_node  = free_r[AW-1:0];
  assign link_prev = prev_rdata;
  // entry 0 of the next links is null until first written
  assign link_next = (nzero_r && !head_ok_r) ? '0 : next_rdata;

  assign stat.cur_zero   = (cursor_r == '0);
  assign stat.pool_full  = (free_r == FULL_CNT);
  assign stat.after_zero = (link_next == '0);

  assign next_raddr = cmd.rd_from_read ? read_r : cursor_r;

  always_comb begin
    next_we    = 1'b0;
    next_waddr = cursor_r;
    next_wdata = new_node;
    if (cmd.wr_fwd) begin
      next_we    = 1'b1;
      next_waddr = new_node;
      next_wdata = link_next;
    end else if (cmd.wr_head) begin
      next_we    = 1'b1;
      next_waddr = cursor_r;
      next_wdata = new_node;
    end else if (cmd.unlink) begin
      next_we    = 1'b1;
      next_waddr = link_prev;
      next_wdata = link_next;
    end
  end

  always_comb begin
    prev_we    = 1'b0;
    prev_waddr = new_node;
    prev_wdata = cursor_r;
    if (cmd.wr_new) begin
      prev_we = 1'b1;
    end else if (cmd.wr_fwd) begin
      prev_we    = !stat.after_zero;
      prev_waddr = link_next;
      prev_wdata = new_node;
    end else if (cmd.unlink) begin
      prev_we    = !stat.after_zero;
      prev_waddr = link_next;
      prev_wdata = link_prev;
    end
  end

  cle_ram #(.WIDTH(AW), .DEPTH(NODES)) u_next (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .re    (cmd.rd_next),
    .raddr (next_raddr),
    .rdata (next_rdata)
  );

  cle_ram #(.WIDTH(AW), .DEPTH(NODES)) u_prev (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .re    (cmd.rd_prev),
    .raddr (cursor_r),
    .rdata (prev_rdata)
  );

  cle_ram #(.WIDTH(CHAR_W), .DEPTH(NODES)) u_char (
    .clk   (clk),
    .we    (cmd.wr_new),
    .waddr (new_node),
    .wdata (char_in),
    .re    (cmd.read_adv),
    .raddr (link_next),
    .rdata (char_rdata)
  );

  always_comb begin
    cursor_nxt  = cursor_r;
    read_nxt    = read_r;
    free_nxt    = free_r;
    head_ok_nxt = head_ok_r || (next_we && (next_waddr == '0));
    nzero_nxt   = cmd.rd_next ? (next_raddr == '0) : nzero_r;
    if (cmd.wr_head) begin
      cursor_nxt = new_node;
      free_nxt   = free_r + 1'b1;
    end else if (cmd.cur_to_prev || cmd.unlink) begin
      cursor_nxt = link_prev;
    end else if (cmd.cur_to_next) begin
      cursor_nxt = link_next;
    end
    if (cmd.read_clr) begin
      read_nxt = '0;
    end else if (cmd.read_adv) begin
      read_nxt = link_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r  <= '0;
      read_r    <= '0;
      free_r    <= (AW+1)'(1);
      head_ok_r <= 1'b0;
      nzero_r   <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      cursor_r  <= cursor_nxt;
      read_r    <= read_nxt;
      free_r    <= free_nxt;
      head_ok_r <= head_ok_nxt;
      nzero_r   <= nzero_nxt;
      valid_r   <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status_r <= cmd.status;
      end_r    <= cmd.at_end;
      char_r   <= cmd.take_char ? char_rdata : '0;
    end
  end

  assign out_valid    = valid_r;
  assign out_status   = status_r;
  assign out_char_out = char_r;
  assign out_at_end   = end_r;

endmodule

`default_nettype wire

// ===== design/cursor_line_editor_list_core.sv =====
// cursor line editor core over cle_ctrl, cle_dpath, cle_ram, cle_pkg and the assertion header
// states from start to result: insert S_INS_LINK, S_INS_HEAD; a read that finds a char
//   S_RD_LINK, S_RD_CHAR; left, delete, right S_MOVE_L, S_DEL, S_MOVE_R; a read at end
//   of text S_RD_LINK; rewind, full-pool insert, left or delete at head, unknown ops S_IDLE;
//   read-then-write links set these; busy drops with the strobe; the receiver cannot stall
// reset (sync, rst_n low): pointers to head, pool count to 1, no clearing pass
`default_nettype none

`include "cursor_line_editor_list_core_assert.svh"

module cursor_line_editor_list_core #(
  parameter int NODES = cle_pkg::NODES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [cle_pkg::OP_W-1:0]      in_op,
  input  wire logic [cle_pkg::CHAR_W-1:0]    in_char_in,
  output logic                               out_valid,
  output logic      [cle_pkg::STAT_W-1:0]    out_status,
  output logic      [cle_pkg::CHAR_W-1:0]    out_char_out,
  output logic                               out_at_end
);
  import cle_pkg::*;

  // controller and datapath talk only through these two structs
  cle_cmd_t  cmd;
  cle_stat_t stat;

  // sequencer: one state per dependent memory step of each word
  cle_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // node pool, pointers and the registered result
  cle_dpath #(.NODES(NODES)) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .char_in      (in_char_in),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_char_out (out_char_out),
    .out_at_end   (out_at_end)
  );

  // an accepted word either keeps the block busy or answers next cycle
  `CLE_ASSERT_NEXT(a_word_progress, clk, rst_n, start && !busy, busy || out_valid)
  // results only come out as the sequencer returns to idle
  `CLE_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_valid, !busy)
  // end of text is an ignored read with no character
  `CLE_ASSERT_NOW(a_end_shape, clk, rst_n, out_valid && out_at_end,
                  out_status == ST_IGNORED && out_char_out == '0)

endmodule

`default_nettype wire

// ===== tb/tb_cursor_line_editor_list_core.sv =====
// self-checking testbench for cursor_line_editor_list_core: directed script, then random words
// depends on cle_pkg and the core; a built-in line editor predictor checks every result word
`timescale 1ns / 1ps

module tb_cursor_line_editor_list_core;
  import cle_pkg::*;

  // a smaller pool than the default, so the random part fills it and keeps going
  localparam int POOL_NODES = 256;
  localparam int LINK_W     = $clog2(POOL_NODES);
  localparam int WORD_GOAL  = 1250;
  localparam int SCRIPT_LEN = 24;

  // op codes that the core does not define
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  typedef logic [LINK_W-1:0] node_t;

  // one expected result word, stamped with the time its command word was taken
  typedef struct {
    logic [STAT_W-1:0] status;
    logic [CHAR_W-1:0] char_out;
    logic              at_end;
    longint unsigned   acc_at;
  } edit_result_t;

  // one command word; fixed marks a row whose result is typed in by hand
  typedef struct {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    bit                fixed;
    logic [STAT_W-1:0] status;
    logic [CHAR_W-1:0] char_out;
    logic              at_end;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [OP_W-1:0] in_op;
  logic [CHAR_W-1:0] in_char_in;
  logic out_valid;
  logic [STAT_W-1:0] out_status;
  logic [CHAR_W-1:0] out_char_out;
  logic out_at_end;

  // predictor copy of the line: pool of linked nodes, cursor and read pointer
  logic [CHAR_W-1:0] line_char [POOL_NODES];
  node_t             back_link [POOL_NODES];
  node_t             fwd_link  [POOL_NODES];
  logic [LINK_W:0]   pool_next;
  node_t             cursor_at;
  node_t             reader_at;
  int                text_len;

  edit_result_t pending_results[$];
  int mismatches = 0;
  int sent_words = 0;
  int quiet_left = 0;

  // directed script: boundaries at reset, unknown ops, byte extremes, insert in the
  // middle, then delete the node under the read pointer and read on through its stale link
  cmd_row_t script [SCRIPT_LEN] = '{
    '{OP_READ,     8'h00, 1'b1, ST_IGNORED, 8'h00, 1'b1},
    '{OP_LEFT,     8'h00, 1'b1, ST_IGNORED, 8'h00, 1'b0},
    '{OP_RIGHT,    8'h00, 1'b1, ST_IGNORED, 8'h00, 1'b0},
    '{OP_DELETE,   8'h00, 1'b1, ST_IGNORED, 8'h00, 1'b0},
    '{OP_REWIND,   8'h00, 1'b1, ST_DONE,    8'h00, 1'b0},
    '{OP_UNUSED_6, 8'hff, 1'b1, ST_IGNORED, 8'h00, 1'b0},
    '{OP_UNUSED_7, 8'h00, 1'b1, ST_IGNORED, 8'h00, 1'b0},
    '{OP_INSERT,   8'h00, 1'b1, ST_DONE,    8'h00, 1'b0},
    '{OP_INSERT,   8'hff, 1'b1, ST_DONE,    8'h00, 1'b0},
    '{OP_INSERT,   8'h41, 1'b1, ST_DONE,    8'h00, 1'b0},
    '{OP_RIGHT,    8'h00, 1'b1, ST_IGNORED, 8'h00, 1'b0},
    '{OP_LEFT,     8'h00, 1'b0, ST_DONE,    8'h00, 1'b0},
    '{OP_LEFT,     8'h00, 1'b0, ST_DONE,    8'h00, 1'b0},
    '{OP_INSERT,   8'h80, 1'b1, ST_DONE,    8'h00, 1'b0},
    '{OP_REWIND,   8'h00, 1'b1, ST_DONE,    8'h00, 1'b0},
    '{OP_READ,     8'h00, 1'b0, ST_DONE,    8'h00, 1'b0},
    '{OP_READ,     8'h00, 1'b0, ST_DONE,    8'h00, 1'b0},
    '{OP_DELETE,   8'h00, 1'b0, ST_DONE,    8'h00, 1'b0},
    '{OP_READ,     8'h00, 1'b0, ST_DONE,    8'h00, 1'b0},
    '{OP_READ,     8'h00, 1'b0, ST_DONE,    8'h00, 1'b0},
    '{OP_READ,     8'h00, 1'b0, ST_DONE,    8'h00, 1'b0},
    '{OP_LEFT,     8'h00, 1'b0, ST_DONE,    8'h00, 1'b0},
    '{OP_DELETE,   8'h00, 1'b0, ST_DONE,    8'h00, 1'b0},
    '{OP_INSERT,   8'h7f, 1'b0, ST_DONE,    8'h00, 1'b0}
  };

  cursor_line_editor_list_core #(
    .NODES(POOL_NODES)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_op       (in_op),
    .in_char_in  (in_char_in),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_char_out(out_char_out),
    .out_at_end  (out_at_end)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // line state after reset: empty line, both pointers on the head node
  task automatic clear_line();
    for (int i = 0; i < POOL_NODES; i++) begin
      line_char[i] = '0;
      back_link[i] = '0;
      fwd_link[i]  = '0;
    end
    pool_next = (LINK_W+1)'(1);
    cursor_at = '0;
    reader_at = '0;
    text_len  = 0;
  endtask

  // applies one command word to the line copy and returns the result word it gives
  function automatic edit_result_t apply_edit(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch);
    edit_result_t r;
    node_t here, after, prior, fresh;
    r.status   = ST_DONE;
    r.char_out = '0;
    r.at_end   = 1'b0;
    r.acc_at   = 0;
    here = cursor_at;
    case (op)
      OP_INSERT: begin
        if (pool_next >= POOL_NODES) begin
          r.status = ST_FULL;
        end else begin
          fresh = pool_next[LINK_W-1:0];
          after = fwd_link[here];
          line_char[fresh] = ch;
          back_link[fresh] = here;
          fwd_link[fresh]  = after;
          if (after != 0) back_link[after] = fresh;
          fwd_link[here] = fresh;
          cursor_at = fresh;
          pool_next = pool_next + 1'b1;
          text_len++;
        end
      end
      OP_LEFT: begin
        if (here == 0) r.status = ST_IGNORED;
        else cursor_at = back_link[here];
      end
      OP_RIGHT: begin
        after = fwd_link[here];
        if (after == 0) r.status = ST_IGNORED;
        else cursor_at = after;
      end
      OP_DELETE: begin
        if (here == 0) begin
          r.status = ST_IGNORED;
        end else begin
          prior = back_link[here];
          after = fwd_link[here];
          fwd_link[prior] = after;
          if (after != 0) back_link[after] = prior;
          cursor_at = prior;
          text_len--;
        end
      end
      OP_REWIND: reader_at = '0;
      OP_READ: begin
        // a read pointer left on a deleted node walks on through that node's old link
        after = fwd_link[reader_at];
        if (after == 0) begin
          r.status = ST_IGNORED;
          r.at_end = 1'b1;
        end else begin
          reader_at  = after;
          r.char_out = line_char[after];
        end
      end
      default: r.status = ST_IGNORED;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 100) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // idle cycles before a word: mostly none or short, a few long, and stretches with none
  function automatic int pick_gap();
    int roll;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      quiet_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // drives one command word, waits for the core to take it, then books its result
  task automatic issue_word(cmd_row_t row);
    int gap;
    edit_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      // start low, junk on the data ports while idle
      start      <= 1'b0;
      in_op      <= OP_W'($urandom);
      in_char_in <= CHAR_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_op      <= row.op;
    in_char_in <= row.ch;
    @(posedge clk);
    while (busy) @(posedge clk);
    // taken at this edge; state moves on even for hand-typed rows
    predicted = apply_edit(row.op, row.ch);
    sent_words++;
    if (row.fixed) begin
      predicted.status   = row.status;
      predicted.char_out = row.char_out;
      predicted.at_end   = row.at_end;
    end
    predicted.acc_at = $time;
    pending_results.push_back(predicted);
  endtask

  task automatic send_cmd(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch);
    cmd_row_t row;
    row.op       = op;
    row.ch       = ch;
    row.fixed    = 1'b0;
    row.status   = ST_DONE;
    row.char_out = '0;
    row.at_end   = 1'b0;
    issue_word(row);
  endtask

  function automatic logic [OP_W-1:0] random_op();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return OP_INSERT;
    if (roll < 45) return OP_LEFT;
    if (roll < 60) return OP_RIGHT;
    if (roll < 72) return OP_DELETE;
    if (roll < 78) return OP_REWIND;
    if (roll < 96) return OP_READ;
    return $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
  endfunction

  // one random round: a lone word, or a typing burst, a cursor run, a read scan
  // or a run of deletes
  task automatic random_round();
    int kind;
    int count;
    logic [OP_W-1:0] dir;
    kind = $urandom_range(0, 99);
    if (kind < 58) begin
      send_cmd(random_op(), CHAR_W'($urandom));
    end else if (kind < 73) begin
      repeat ($urandom_range(1, 8)) send_cmd(OP_INSERT, CHAR_W'($urandom));
    end else if (kind < 83) begin
      dir = $urandom_range(0, 1) ? OP_LEFT : OP_RIGHT;
      // now and then run off the end of the line in that direction
      count = ($urandom_range(0, 9) < 3) ? text_len + 1 : $urandom_range(1, 12);
      repeat (count) send_cmd(dir, CHAR_W'($urandom));
    end else if (kind < 93) begin
      send_cmd(OP_REWIND, CHAR_W'($urandom));
      count = ($urandom_range(0, 9) < 4) ? text_len + $urandom_range(0, 2)
                                         : $urandom_range(1, 8);
      repeat (count) send_cmd(OP_READ, CHAR_W'($urandom));
    end else begin
      repeat ($urandom_range(1, 10)) send_cmd(OP_DELETE, CHAR_W'($urandom));
    end
  endtask

  // result side: every strobe must match the oldest word still owed
  always @(posedge clk) begin : result_check
    edit_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0 || pending_results[0].acc_at >= $time) begin
        report_mismatch($sformatf("result word with none pending, status %0d char %0d",
                                  out_status, out_char_out));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_char_out !== want.char_out)
          report_mismatch($sformatf("char_out %0d, want %0d", out_char_out, want.char_out));
        if (out_at_end !== want.at_end)
          report_mismatch($sformatf("at_end %0d, want %0d", out_at_end, want.at_end));
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_op      = OP_INSERT;
    in_char_in = '0;
    clear_line();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed script
    for (int i = 0; i < SCRIPT_LEN; i++) issue_word(script[i]);

    // random words up to the word budget; the pool fills along the way
    while (sent_words < WORD_GOAL) random_round();

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // catch any stray strobe after the last owed word
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog well past the slowest legal run
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
